[hw/rtl/efla_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes of the extent free-list allocator.
// No dependencies.
package efla_pkg;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FIN,
		ST_DONE
	} state_t;

	// what the scan step decided
	typedef enum logic [2:0] {
		ACT_NEXT,
		ACT_NOFIT,
		ACT_FULL,
		ACT_MOD,
		ACT_INS,
		ACT_REM
	} act_t;

endpackage

[hw/rtl/efla_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// No dependencies.
interface efla_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] request_start;
	logic [15:0] request_length;

	modport source (output valid, kind, request_start, request_length, input ready);
	modport sink (input valid, kind, request_start, request_length, output ready);
endinterface

interface efla_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [4:0] free_extent_count;

	modport source (output valid, status, free_extent_count, input ready);
	modport sink (input valid, status, free_extent_count, output ready);
endinterface

[hw/rtl/efla_ext_mem.sv]
`timescale 1ns / 1ps
// Extent table storage: one write port, one read port, registered read data.
// No dependencies.
module efla_ext_mem #(
	parameter int DEPTH = 15,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[hw/rtl/extent_free_list_allocator.sv]
`timescale 1ns / 1ps
// Extent free-list allocator: one request in, one status beat out.
// Depends on efla_pkg, efla_if and efla_ext_mem.
//
// Keeps an address-sorted table of free extents. The head extent (begin 0) sits in a
// register, the other entries in a one-read one-write table memory. A request is taken
// only when the block is idle. It walks the table one entry per cycle on the read port
// until it finds the place, then moves the entries behind an insert or removal one per
// cycle. A request that edits one entry in place or is rejected ends with the scan;
// a removal then runs the shift state, an insert the shift state and a final
// write of the new entry. A zero-length or out-of-range request skips the scan.
// The result beat sits in an output register, so a new request is taken while it waits.
// Writing total_size resets the table to [0,total_size) at once; no clearing pass.
module extent_free_list_allocator
	import efla_pkg::*;
#(
	parameter int MAX_EXTENTS = 16,
	parameter int ADDR_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        total_size_we,
	input  logic [15:0] total_size_wdata,
	efla_req_if.sink    req,
	efla_rsp_if.source  rsp
);

	localparam int AB = ADDR_BITS;
	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);

	state_t          st_q, st_d;
	act_t            act;
	logic [IW-1:0]   k_q, k_d;
	logic [CW-1:0]   used_q, used_d;
	logic [AB-1:0]   head_fin_q, head_fin_d;
	logic            kind_q, kind_d;
	logic [AB-1:0]   s_q, s_d, e_q, e_d;
	logic [AB-1:0]   pb_q, pb_d, pf_q, pf_d;
	logic [IW-1:0]   tgt_q, tgt_d;
	logic            ins_q, ins_d;
	logic [AB-1:0]   fb_q, fb_d, ff_q, ff_d;
	logic [CW-1:0]   src_q, src_d;
	logic            pend_s1, pend_d;
	logic [IW-1:0]   dst_s1, dst_d;
	logic [1:0]      code_q, code_d;
	logic            out_v_q;
	logic [1:0]      out_st_q;
	logic [4:0]      out_cnt_q;

	logic              wr_en;
	logic [IW-1:0]     wr_addr, rd_addr;
	logic [2*AB-1:0]   wr_data, rd_data;

	logic [31:0]     st32, ln32, tot32, cnt32;
	logic [AB-1:0]   in_s, in_len, in_tot;
	logic [AB:0]     in_sum;
	logic            accept, out_free;

	logic [AB-1:0]   cur_b, cur_f;
	logic            last, full, in_range;
	logic            mod_en;
	logic [IW-1:0]   mod_idx, tq;
	logic [AB-1:0]   mod_b, mod_f, tb, tf;
	logic            hit, kl, rt, gap, mprev, mnext;

	efla_ext_mem #(
		.DEPTH (MAX_EXTENTS - 1),
		.WIDTH (2 * AB),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign st32   = 32'(req.request_start);
	assign ln32   = 32'(req.request_length);
	assign tot32  = 32'(total_size_wdata);
	assign in_s   = st32[AB-1:0];
	assign in_len = ln32[AB-1:0];
	assign in_tot = tot32[AB-1:0];
	assign in_sum = {1'b0, in_s} + {1'b0, in_len};

	assign req.ready = (st_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_v_q || rsp.ready;

	// entry 0 begins at 0 and lives in a register
	assign cur_b = (k_q == '0) ? '0 : rd_data[2*AB-1:AB];
	assign cur_f = (k_q == '0) ? head_fin_q : rd_data[AB-1:0];
	assign last  = (CW'(k_q) == used_q - CW'(1));
	assign full  = (used_q >= CW'(MAX_EXTENTS));
	assign in_range = ins_q ? (src_q >= CW'(tgt_q)) : (src_q < used_q);

	// scan decision for the entry at k
	always_comb begin
		act     = ACT_NEXT;
		mod_en  = 1'b0;
		mod_idx = k_q;
		mod_b   = cur_b;
		mod_f   = cur_f;
		tq      = k_q;
		tb      = s_q;
		tf      = e_q;
		hit     = (cur_b <= s_q) && (cur_f >= e_q);
		kl      = (k_q == '0) || (cur_b != s_q);
		rt      = (e_q != cur_f);
		gap     = (k_q != '0) && (pf_q <= s_q) && (cur_b >= e_q);
		mprev   = (pf_q == s_q);
		mnext   = (cur_b == e_q);
		if (kind_q == KIND_ALLOC) begin
			if (hit) begin
				if (kl && rt) begin
					act    = full ? ACT_FULL : ACT_INS;
					mod_en = !full;
					mod_f  = s_q;
					tq     = k_q + IW'(1);
					tb     = e_q;
					tf     = cur_f;
				end else if (kl) begin
					act    = ACT_MOD;
					mod_en = 1'b1;
					mod_f  = s_q;
				end else if (rt) begin
					act    = ACT_MOD;
					mod_en = 1'b1;
					mod_b  = e_q;
				end else begin
					act = ACT_REM;
				end
			end else if (last) begin
				act = ACT_NOFIT;
			end
		end else begin
			if (gap) begin
				if (mprev && mnext) begin
					act     = ACT_REM;
					mod_en  = 1'b1;
					mod_idx = k_q - IW'(1);
					mod_b   = pb_q;
				end else if (mprev) begin
					act     = ACT_MOD;
					mod_en  = 1'b1;
					mod_idx = k_q - IW'(1);
					mod_b   = pb_q;
					mod_f   = e_q;
				end else if (mnext) begin
					act    = ACT_MOD;
					mod_en = 1'b1;
					mod_b  = s_q;
				end else begin
					act = full ? ACT_FULL : ACT_INS;
				end
			end else if (last) begin
				if (cur_f == s_q) begin
					act    = ACT_MOD;
					mod_en = 1'b1;
					mod_f  = e_q;
				end else if (cur_f < s_q) begin
					act = full ? ACT_FULL : ACT_INS;
					tq  = IW'(used_q);
				end else begin
					act = ACT_NOFIT;
				end
			end
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					st_d = (in_len == '0 || in_sum[AB]) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				unique case (act)
					ACT_NEXT: st_d = ST_SCAN;
					ACT_INS, ACT_REM: st_d = ST_SHIFT;
					default: st_d = ST_DONE;
				endcase
			end
			ST_SHIFT: begin
				if (!in_range && !pend_s1) begin
					st_d = ins_q ? ST_FIN : ST_DONE;
				end
			end
			ST_FIN: st_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// datapath and table writes
	always_comb begin
		k_d        = k_q;
		used_d     = used_q;
		head_fin_d = head_fin_q;
		kind_d     = kind_q;
		s_d        = s_q;
		e_d        = e_q;
		pb_d       = pb_q;
		pf_d       = pf_q;
		tgt_d      = tgt_q;
		ins_d      = ins_q;
		fb_d       = fb_q;
		ff_d       = ff_q;
		src_d      = src_q;
		pend_d     = 1'b0;
		dst_d      = dst_s1;
		code_d     = code_q;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = rd_data;
		rd_addr    = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					k_d    = '0;
					kind_d = req.kind;
					s_d    = in_s;
					e_d    = in_sum[AB-1:0];
					code_d = (in_len != '0 && in_sum[AB]) ? STAT_NOFIT : STAT_DONE;
				end
				if (total_size_we) begin
					head_fin_d = in_tot;
					used_d     = CW'(1);
				end
			end
			ST_SCAN: begin
				rd_addr = k_q;
				k_d     = k_q + IW'(1);
				pb_d    = cur_b;
				pf_d    = cur_f;
				tgt_d   = tq;
				fb_d    = tb;
				ff_d    = tf;
				ins_d   = (act == ACT_INS);
				src_d   = (act == ACT_INS) ? used_q - CW'(1) : CW'(tq) + CW'(1);
				unique case (act)
					ACT_NOFIT: code_d = STAT_NOFIT;
					ACT_FULL:  code_d = STAT_FULL;
					default:   code_d = STAT_DONE;
				endcase
				if (mod_en) begin
					if (mod_idx == '0) begin
						head_fin_d = mod_f;
					end else begin
						wr_en   = 1'b1;
						wr_addr = mod_idx - IW'(1);
						wr_data = {mod_b, mod_f};
					end
				end
			end
			ST_SHIFT: begin
				rd_addr = IW'(src_q - CW'(1));
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = dst_s1 - IW'(1);
					wr_data = rd_data;
				end
				if (in_range) begin
					pend_d = 1'b1;
					dst_d  = ins_q ? IW'(src_q + CW'(1)) : IW'(src_q - CW'(1));
					src_d  = ins_q ? src_q - CW'(1) : src_q + CW'(1);
				end else if (!pend_s1 && !ins_q) begin
					used_d = used_q - CW'(1);
				end
			end
			ST_FIN: begin
				wr_en   = 1'b1;
				wr_addr = tgt_q - IW'(1);
				wr_data = {fb_q, ff_q};
				used_d  = used_q + CW'(1);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign cnt32 = 32'(used_q) - ((head_fin_q == '0) ? 32'd1 : 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			used_q     <= CW'(1);
			head_fin_q <= AB'(32'hFFFF);
			pend_s1    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			st_q       <= st_d;
			used_q     <= used_d;
			head_fin_q <= head_fin_d;
			pend_s1    <= pend_d;
			if (st_q == ST_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q    <= k_d;
		kind_q <= kind_d;
		s_q    <= s_d;
		e_q    <= e_d;
		pb_q   <= pb_d;
		pf_q   <= pf_d;
		tgt_q  <= tgt_d;
		ins_q  <= ins_d;
		fb_q   <= fb_d;
		ff_q   <= ff_d;
		src_q  <= src_d;
		dst_s1 <= dst_d;
		code_q <= code_d;
		if (st_q == ST_DONE && out_free) begin
			out_st_q  <= code_q;
			out_cnt_q <= cnt32[4:0];
		end
	end

	assign rsp.valid             = out_v_q;
	assign rsp.status            = out_st_q;
	assign rsp.free_extent_count = out_cnt_q;

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != '0 && used_q <= CW'(MAX_EXTENTS))
		else $error("extent count out of range");

	a_pend_shift: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> st_q == ST_SHIFT)
		else $error("pending move outside shift phase");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == STAT_DONE || rsp.status == STAT_NOFIT ||
			rsp.status == STAT_FULL))
		else $error("bad status code");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.request_length == '0 |=> st_q == ST_DONE)
		else $error("zero-length request did not finish at once");

endmodule
